@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRFC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("srfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRFC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("srfc assertion failed");

// Next-cycle implication that is also checked across reset.
`define SRFC_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("srfc assertion failed");

`endif

@@ design/srfc_pkg.sv @@
// Package with the item types and codes of the shadow register file checker.
`timescale 1ns / 1ps

package srfc_pkg;

    localparam logic [2:0] OP_WRITE        = 3'd0;
    localparam logic [2:0] OP_CHECK        = 3'd1;
    localparam logic [2:0] OP_SWEEP_BEGIN  = 3'd2;
    localparam logic [2:0] OP_SWEEP_STEP   = 3'd3;
    localparam logic [2:0] OP_COMPOSE      = 3'd4;
    localparam logic [2:0] OP_READ_COUNTER = 3'd5;

    localparam logic [1:0] FIND_NONE    = 2'd0;
    localparam logic [1:0] FIND_DIVERGE = 2'd1;
    localparam logic [1:0] FIND_EXTERN  = 2'd2;

    localparam int NUM_COUNTERS = 8;

    localparam logic [2:0] CNT_CHECKS   = 3'd0;
    localparam logic [2:0] CNT_DIVERGE  = 3'd1;
    localparam logic [2:0] CNT_EXTERNS  = 3'd2;
    localparam logic [2:0] CNT_WRITES   = 3'd3;
    localparam logic [2:0] CNT_IGNORED  = 3'd4;
    localparam logic [2:0] CNT_DEFINED  = 3'd5;
    localparam logic [2:0] CNT_COMPARES = 3'd6;
    localparam logic [2:0] CNT_SWEEPS   = 3'd7;

    localparam logic [3:0] SEL_CURSOR = 4'd8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] reg_index;
        logic [31:0] write_value;
        logic [31:0] live_value;
        logic [3:0]  counter_select;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  finding_kind;
        logic [15:0] finding_reg;
        logic [31:0] shadow_out;
        logic [31:0] live_out;
        logic [31:0] data_out;
    } t_out_item;

    typedef struct packed {
        t_in_item item;
        logic     in_range;
    } t_cmd;

endpackage

@@ design/srfc_fifo.sv @@
// Two-entry queue used between the front and back and for the results.
`timescale 1ns / 1ps

module srfc_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           push_ok;
    logic           pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/srfc_front.sv @@
// Front end that accepts items, classifies their register index and queues them.
`timescale 1ns / 1ps

module srfc_front #(
    parameter int REG_COUNT = 16384
) (
    input  logic             i_push,
    input  srfc_pkg::t_in_item i_item,
    input  logic             i_clearing,
    input  logic             i_queue_full,
    output logic             o_full,
    output logic             o_queue_push,
    output srfc_pkg::t_cmd   o_cmd
);

    import srfc_pkg::*;

    localparam logic [15:0] INDEX_LIMIT = 16'(REG_COUNT);

    assign o_full         = i_clearing | i_queue_full;
    assign o_queue_push   = i_push & ~o_full;
    assign o_cmd.item     = i_item;
    assign o_cmd.in_range = (i_item.reg_index < INDEX_LIMIT);

endmodule

@@ design/srfc_back.sv @@
// Back end with the shadow memory, event counters, sweep cursor and clearing pass.
`timescale 1ns / 1ps

module srfc_back #(
    parameter int REG_COUNT = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  srfc_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output srfc_pkg::t_out_item o_res,
    output logic                o_clearing
);

    import srfc_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CW = $clog2(REG_COUNT + 1);
    localparam logic [CW-1:0] CURSOR_LIMIT = CW'(REG_COUNT);
    localparam logic [AW-1:0] LAST_INDEX   = AW'(REG_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr_idx;
    logic [CW-1:0]      r_cursor;
    logic [CW-1:0]      n_cursor;
    logic [31:0]        r_counters [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] inc;
    t_cmd               r_cmd;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      n_addr;
    logic               r_wrap;
    logic               cur_wrap;
    logic [32:0]        r_mem [REG_COUNT];
    logic [32:0]        r_rd_data;
    logic               mem_re;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [32:0]        mem_wdata;
    logic               exec_go;
    logic               do_cmp;
    logic               rd_def;
    logic [31:0]        rd_val;
    logic [31:0]        live;
    t_out_item          res;

    assign o_clearing = (r_state == S_CLEAR);
    assign mem_re     = (r_state == S_IDLE) & i_cmd_valid;
    assign o_cmd_pop  = mem_re;
    assign exec_go    = (r_state == S_EXEC) & ~i_res_full;
    assign cur_wrap   = (r_cursor >= CURSOR_LIMIT);
    assign rd_def     = r_rd_data[32];
    assign rd_val     = r_rd_data[31:0];
    assign live       = r_cmd.item.live_value;

    always_comb begin
        if (i_cmd.item.opcode == OP_SWEEP_STEP) begin
            n_addr = cur_wrap ? '0 : r_cursor[AW-1:0];
        end else if (i_cmd.in_range) begin
            n_addr = i_cmd.item.reg_index[AW-1:0];
        end else begin
            n_addr = '0;
        end
    end

    assign mem_we    = o_clearing |
                       (exec_go & (r_cmd.item.opcode == OP_WRITE) & r_cmd.in_range);
    assign mem_waddr = o_clearing ? r_clr_idx : r_addr;
    assign mem_wdata = o_clearing ? 33'd0 : {1'b1, r_cmd.item.write_value};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[n_addr];
        end
    end

    always_comb begin
        res      = '0;
        inc      = '0;
        n_cursor = r_cursor;
        do_cmp   = 1'b0;
        case (r_cmd.item.opcode)
            OP_WRITE: begin
                if (r_cmd.in_range) begin
                    inc[CNT_WRITES] = 1'b1;
                    if (!rd_def) begin
                        inc[CNT_DEFINED] = 1'b1;
                    end
                end else begin
                    inc[CNT_IGNORED] = 1'b1;
                end
            end
            OP_CHECK: begin
                if (r_cmd.in_range) begin
                    do_cmp = 1'b1;
                end else begin
                    res.finding_reg = r_cmd.item.reg_index;
                end
            end
            OP_SWEEP_BEGIN: begin
                inc[CNT_COMPARES] = 1'b1;
            end
            OP_SWEEP_STEP: begin
                do_cmp = 1'b1;
                if (r_wrap) begin
                    inc[CNT_SWEEPS] = 1'b1;
                end
                n_cursor = CW'(r_addr) + 1'b1;
            end
            OP_COMPOSE: begin
                res.finding_reg = r_cmd.item.reg_index;
                res.data_out    = (r_cmd.in_range && rd_def) ? rd_val : live;
            end
            OP_READ_COUNTER: begin
                if (r_cmd.item.counter_select < 4'(NUM_COUNTERS)) begin
                    res.data_out = r_counters[r_cmd.item.counter_select[2:0]];
                end else if (r_cmd.item.counter_select == SEL_CURSOR) begin
                    res.data_out = 32'(r_cursor);
                end
            end
            default: begin
            end
        endcase
        if (do_cmp) begin
            inc[CNT_CHECKS] = 1'b1;
            res.finding_reg = 16'(r_addr);
            if (rd_def) begin
                if (rd_val != live) begin
                    inc[CNT_DIVERGE]  = 1'b1;
                    res.finding_kind  = FIND_DIVERGE;
                    res.shadow_out    = rd_val;
                    res.live_out      = live;
                end
            end else if (live != 32'd0) begin
                inc[CNT_EXTERNS] = 1'b1;
                res.finding_kind = FIND_EXTERN;
                res.live_out     = live;
            end
        end
    end

    assign o_res_push = exec_go;
    assign o_res      = res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == LAST_INDEX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_cursor  <= '0;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_counters[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (exec_go) begin
                r_cursor <= n_cursor;
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    r_counters[k] <= r_counters[k] + 32'(inc[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_cmd  <= i_cmd;
            r_addr <= n_addr;
            r_wrap <= cur_wrap;
        end
    end

endmodule

@@ design/shadow_register_file_checker_top.sv @@
// Top level of the shadow register file checker.
// An accepted item passes through the command queue, the registered shadow memory read and the result queue.
// The back end reads and executes one item before it takes the next, set by the registered read of the shadow memory.
// After reset, full stays high while a pass clears every defined bit.
// Reset is synchronous and active low; counters, cursor and queues start empty.
`timescale 1ns / 1ps

module shadow_register_file_checker_top #(
    parameter int REG_COUNT = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  srfc_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output srfc_pkg::t_out_item o_item
);

    import srfc_pkg::*;

    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    logic      front_push;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      clearing;
    logic      res_push;
    logic      res_full;
    t_out_item res_item;

    srfc_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .i_push       (push),
        .i_item       (i_item),
        .i_clearing   (clearing),
        .i_queue_full (cmd_full),
        .o_full       (full),
        .o_queue_push (front_push),
        .o_cmd        (front_cmd)
    );

    srfc_fifo #(
        .T (t_cmd)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (queue_cmd),
        .o_empty (cmd_empty)
    );

    srfc_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (~cmd_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_item),
        .o_clearing  (clearing)
    );

    srfc_fifo #(
        .T (t_out_item)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );

endmodule

@@ design/srfc_checker.sv @@
// Port-level checker for the shadow register file checker and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srfc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_push,
    input logic                i_full,
    input logic                i_empty,
    input logic                i_pop,
    input srfc_pkg::t_out_item i_out
);

    import srfc_pkg::*;

    logic [3:0] r_pending;
    logic [3:0] n_pending;
    logic       in_ok;
    logic       out_ok;
    logic       out_diverge;

    assign in_ok       = i_push & ~i_full;
    assign out_ok      = i_pop & ~i_empty;
    assign out_diverge = !i_empty && (i_out.finding_kind == FIND_DIVERGE);

    always_comb begin
        n_pending = r_pending;
        if (in_ok && !out_ok) begin
            n_pending = r_pending + 1'b1;
        end else if (out_ok && !in_ok) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `SRFC_ASSERT_NEXT_ALWAYS(a_reset_closed, i_clk, !i_rst_n, i_full && i_empty)
    `SRFC_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, !i_empty, r_pending != 4'd0)
    `SRFC_ASSERT_IMP(a_bounded, i_clk, i_rst_n, 1'b1, r_pending <= 4'd5)
    `SRFC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_out))
    `SRFC_ASSERT_IMP(a_diverge, i_clk, i_rst_n, out_diverge, i_out.shadow_out != i_out.live_out)

endmodule

bind shadow_register_file_checker_top srfc_checker u_srfc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (push),
    .i_full  (full),
    .i_empty (empty),
    .i_pop   (pop),
    .i_out   (o_item)
);
